// File: sv/rghn_pkg.sv
// shared types and constants of the histogram normalizer
package rghn_pkg;

  localparam int unsigned CountWidth    = 24;
  localparam int unsigned BinCount      = 256;
  localparam int unsigned LevelFracBits = 15;
  localparam int unsigned BinWidth      = 8;
  localparam int unsigned LevelWidth    = 16;

  localparam logic [1:0] FuncClear = 2'd0;
  localparam logic [1:0] FuncPixel = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  // control handed from the top level to the divider lanes
  typedef struct packed {
    logic start;
    logic zero_max;
  } div_ctrl_t;

endpackage

// File: sv/rghn_if.sv
// request and result channels of the histogram normalizer
interface rghn_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       last_pixel;
  logic [7:0] bin_index;
  modport source (output valid, func, pixel_red, pixel_green, pixel_blue, last_pixel,
                  bin_index, input ready);
  modport sink (input valid, func, pixel_red, pixel_green, pixel_blue, last_pixel,
                bin_index, output ready);
endinterface

interface rghn_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_echo;
  logic [15:0] red_level;
  logic [15:0] green_level;
  logic [15:0] blue_level;
  logic [15:0] grey_level;
  modport source (output valid, bin_echo, red_level, green_level, blue_level, grey_level,
                  input ready);
  modport sink (input valid, bin_echo, red_level, green_level, blue_level, grey_level,
                output ready);
endinterface

// File: sv/rgb_grey_histogram_normalizer.sv
// top level: histogram memories, maxima walk and four divider lanes
// Usage: requests arrive on req (func clear, pixel or read), results leave on res.
// Bin updates of pixel requests go through a read-modify-write pipeline with
// forwarding, so pixels stream at one per cycle while req is ready.
// A pixel with last_pixel set starts a walk of all 256 bins, one bin a cycle,
// while no request is taken; it sets both maxima.
// A clear request sweeps all 256 bins, one a cycle, zeroing them and the maxima.
// After reset the same clearing pass runs before req is ready.
// A read request fetches the bin, waiting while any pixel still in the pipeline
// drains, then four lanes divide side by side, one quotient bit a cycle.
// Pixels overlap, but a clear, walk or read runs alone; a read result waits in
// the output register until res.ready and no new request is taken meanwhile.
// The rate is set by the bin memory walk and the bit-serial divider lanes.
// Func code 3 is accepted and ignored.
module rgb_grey_histogram_normalizer #(
  parameter int unsigned COUNT_WIDTH     = rghn_pkg::CountWidth,
  parameter int unsigned LEVEL_FRAC_BITS = rghn_pkg::LevelFracBits
) (
  input logic clk_i,
  input logic rst_ni,
  rghn_req_if.sink   req,
  rghn_res_if.source res
);
  import rghn_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    StClear, StRun, StWalkRd, StWalk, StReadRd, StReadGrey, StDiv, StOut
  } state_e;

  state_e state_q;
  logic [BinWidth-1:0] idx_q;
  logic [BinWidth:0]   cnt_q;
  logic [CW-1:0] cmax_q, gmax_q;
  logic [BinWidth-1:0] echo_q;

  logic [CW-1:0] red_mem [BinCount];
  logic [CW-1:0] grn_mem [BinCount];
  logic [CW-1:0] blu_mem [BinCount];
  logic [CW-1:0] red_rd, grn_rd, blu_rd;
  logic [BinWidth-1:0] ra_r, ra_g, ra_b;

  // pixel pipeline: stage 1 reads, stage 2 writes
  logic p1_q;
  logic [BinWidth-1:0] a1r_q, a1g_q, a1b_q;
  logic [CW-1:0] wr_r_q, wr_g_q, wr_b_q;
  logic [BinWidth-1:0] war_q, wag_q, wab_q;
  logic we_q;
  logic [CW-1:0] wd2_r_q, wd2_g_q, wd2_b_q;
  logic [BinWidth-1:0] wa2r_q, wa2g_q, wa2b_q;
  logic we2_q;
  logic [CW-1:0] cur_r, cur_g, cur_b;

  logic accept;
  assign req.ready = (state_q == StRun);
  assign accept    = req.valid && req.ready;

  // read address select
  always_comb begin
    ra_r = req.pixel_red;
    ra_g = req.pixel_green;
    ra_b = req.pixel_blue;
    if (state_q != StRun) begin
      ra_r = idx_q;
      ra_g = idx_q;
      ra_b = idx_q;
    end else if (req.func == FuncRead) begin
      ra_r = req.bin_index;
      ra_g = req.bin_index;
      ra_b = req.bin_index;
    end
  end

  // forwarding from the write stage (previous pixel) and from the pixel before it
  always_comb begin
    cur_r = red_rd;
    cur_g = grn_rd;
    cur_b = blu_rd;
    if (we2_q && wa2r_q == a1r_q) cur_r = wd2_r_q;
    if (we2_q && wa2g_q == a1g_q) cur_g = wd2_g_q;
    if (we2_q && wa2b_q == a1b_q) cur_b = wd2_b_q;
    if (we_q && war_q == a1r_q) cur_r = wr_r_q;
    if (we_q && wag_q == a1g_q) cur_g = wr_g_q;
    if (we_q && wab_q == a1b_q) cur_b = wr_b_q;
  end

  logic clr_we;
  assign clr_we = (state_q == StClear);

  always_ff @(posedge clk_i) begin
    red_rd <= red_mem[ra_r];
    grn_rd <= grn_mem[ra_g];
    blu_rd <= blu_mem[ra_b];
    if (clr_we) begin
      red_mem[idx_q] <= '0;
      grn_mem[idx_q] <= '0;
      blu_mem[idx_q] <= '0;
    end else if (we_q) begin
      red_mem[war_q] <= wr_r_q;
      grn_mem[wag_q] <= wr_g_q;
      blu_mem[wab_q] <= wr_b_q;
    end
  end

  // a read of an address being written in the same cycle sees old data,
  // so the stage-1 forward also checks the write just done, held in the we2_q registers
  logic [CW-1:0] nr, ng, nb;
  assign nr = (cur_r == CountMax) ? cur_r : cur_r + 1'b1;
  assign ng = (cur_g == CountMax) ? cur_g : cur_g + 1'b1;
  assign nb = (cur_b == CountMax) ? cur_b : cur_b + 1'b1;

  always_ff @(posedge clk_i) begin
    a1r_q   <= req.pixel_red;
    a1g_q   <= req.pixel_green;
    a1b_q   <= req.pixel_blue;
    wr_r_q  <= nr;
    wr_g_q  <= ng;
    wr_b_q  <= nb;
    war_q   <= a1r_q;
    wag_q   <= a1g_q;
    wab_q   <= a1b_q;
    wd2_r_q <= wr_r_q;
    wd2_g_q <= wr_g_q;
    wd2_b_q <= wr_b_q;
    wa2r_q  <= war_q;
    wa2g_q  <= wag_q;
    wa2b_q  <= wab_q;
  end

  // grey of the registered bin, for the walk and the grey divider lane
  logic [CW+5:0] gsum;
  logic [CW-1:0] grey_w;
  logic [CW-1:0] wr_q, wg_q, wb_q, wgr_q;
  logic          wv_q;
  assign gsum   = 6'd11 * (CW+6)'(red_rd) + ((CW+6)'(grn_rd) << 4) + 6'd5 * (CW+6)'(blu_rd);
  assign grey_w = gsum[CW+4:5];

  // divider lanes
  logic [3:0] busy;
  div_ctrl_t  dc_col, dc_grey;
  logic [LevelWidth-1:0] lv [4];
  logic [CW+1:0] num [4];
  assign num[0] = (CW+2)'(red_rd);
  assign num[1] = (CW+2)'(grn_rd);
  assign num[2] = (CW+2)'(blu_rd);
  assign num[3] = (CW+2)'(grey_w);
  logic start;
  assign dc_col.start     = start;
  assign dc_col.zero_max  = (cmax_q == '0);
  assign dc_grey.start    = start;
  assign dc_grey.zero_max = (gmax_q == '0);

  for (genvar l = 0; l < 4; l++) begin : g_lane
    rghn_div_lane #(.COUNT_WIDTH(CW), .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_lane (
      .clk_i, .rst_ni,
      .ctrl_i  (l == 3 ? dc_grey : dc_col),
      .count_i (num[l]),
      .max_i   (l == 3 ? gmax_q : cmax_q),
      .busy_o  (busy[l]),
      .level_o (lv[l])
    );
  end

  assign start = (state_q == StReadGrey);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q   <= '0;
      cnt_q   <= '0;
      cmax_q  <= '0;
      gmax_q  <= '0;
      p1_q    <= 1'b0;
      we_q    <= 1'b0;
      we2_q   <= 1'b0;
      wv_q    <= 1'b0;
    end else begin
      we2_q <= we_q;
      we_q  <= p1_q;
      p1_q  <= accept && req.func == FuncPixel;
      wv_q  <= (state_q == StWalk);
      case (state_q)
        StClear: begin
          cmax_q <= '0;
          gmax_q <= '0;
          idx_q  <= idx_q + 1'b1;
          if (idx_q == '1) state_q <= StRun;
        end
        StRun: begin
          if (accept) begin
            case (req.func)
              FuncClear: begin
                idx_q   <= '0;
                state_q <= StClear;
              end
              FuncPixel: if (req.last_pixel) begin
                idx_q   <= '0;
                cnt_q   <= '0;
                state_q <= StWalkRd;
              end
              FuncRead: begin
                idx_q   <= req.bin_index;
                state_q <= StReadRd;
              end
              default: ;
            endcase
          end
        end
        StWalkRd: begin
          // let the pixel pipeline drain into memory
          if (!p1_q && !we_q) begin
            cmax_q  <= '0;
            gmax_q  <= '0;
            idx_q   <= idx_q + 1'b1;
            cnt_q   <= '0;
            state_q <= StWalk;
          end else begin
            idx_q <= '0;
          end
        end
        StWalk: begin
          // idx_q runs one ahead of the data in red_rd
          idx_q <= idx_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (BinWidth+1)'(BinCount)) state_q <= StRun;
        end
        // wait until the last pixel write has landed before the final fetch
        StReadRd:   if (!p1_q && !we_q) state_q <= StReadGrey;
        StReadGrey: state_q <= StDiv;
        StDiv:      if (busy == '0) state_q <= StOut;
        StOut:      if (res.ready) state_q <= StRun;
        default:    state_q <= StClear;
      endcase
      if (wv_q) begin
        if (wr_q > cmax_q) begin
          if (wr_q >= wg_q && wr_q >= wb_q) cmax_q <= wr_q;
          else if (wg_q >= wb_q) cmax_q <= wg_q;
          else cmax_q <= wb_q;
        end else if (wg_q > cmax_q || wb_q > cmax_q) begin
          cmax_q <= (wg_q >= wb_q) ? wg_q : wb_q;
        end
        if (wgr_q > gmax_q) gmax_q <= wgr_q;
      end
    end
  end

  // walk data register
  always_ff @(posedge clk_i) begin
    wr_q  <= (state_q == StWalk) ? red_rd : '0;
    wg_q  <= (state_q == StWalk) ? grn_rd : '0;
    wb_q  <= (state_q == StWalk) ? blu_rd : '0;
    wgr_q <= grey_w;
    if (state_q == StReadRd) echo_q <= idx_q;
  end

  assign res.valid       = (state_q == StOut);
  assign res.bin_echo    = echo_q;
  assign res.red_level   = lv[0];
  assign res.green_level = lv[1];
  assign res.blue_level  = lv[2];
  assign res.grey_level  = lv[3];
endmodule

// File: sv/rghn_div_lane.sv
// one restoring divider lane: floor(count * 2^F / max), saturated at one
module rghn_div_lane #(
  parameter int unsigned COUNT_WIDTH     = 24,
  parameter int unsigned LEVEL_FRAC_BITS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rghn_pkg::div_ctrl_t           ctrl_i,
  input  logic [COUNT_WIDTH+1:0]        count_i,
  input  logic [COUNT_WIDTH-1:0]        max_i,
  output logic                          busy_o,
  output logic [rghn_pkg::LevelWidth-1:0] level_o
);
  import rghn_pkg::*;

  localparam int unsigned NumW  = COUNT_WIDTH + 2 + LEVEL_FRAC_BITS;
  localparam int unsigned StepW = $clog2(NumW + 1);
  localparam int unsigned RemW  = COUNT_WIDTH + 1;
  localparam logic [NumW-1:0] One = NumW'(1) << LEVEL_FRAC_BITS;

  logic [NumW-1:0]  num_q, num_d, quo_q, quo_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, zero_q, zero_d;
  logic [RemW-1:0]  trial;
  logic [NumW-1:0]  sat;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    zero_d = zero_q;
    trial  = {rem_q[RemW-2:0], num_q[NumW-1]};
    if (ctrl_i.start) begin
      num_d  = NumW'(count_i) << LEVEL_FRAC_BITS;
      quo_d  = '0;
      rem_d  = '0;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
      zero_d = ctrl_i.zero_max;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= RemW'(max_i)) begin
        rem_d = trial - RemW'(max_i);
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    zero_q <= zero_d;
  end

  assign sat     = (quo_q > One) ? One : quo_q;
  assign busy_o  = busy_q;
  assign level_o = zero_q ? '0 : sat[LevelWidth-1:0];
endmodule
